// ===== hw/rtl/ppp_pkg.sv =====
// Shared constants, widths and helper functions for the perspective point projector.
// No dependencies; imported by perspective_point_projector_core.
package ppp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int CFG_W     = 14;
  localparam int HALF_W    = CFG_W - 1;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int CLIP_W    = PROD_W - FRAC_BITS + 2;
  localparam int QB        = 17;
  localparam int NUM_W     = HALF_W + CLIP_W;
  localparam int DIV_W     = CLIP_W + QB + 1;
  localparam int T_W       = QB + 3;
  localparam int PIX_W     = 16;

  localparam logic       REG_IMAGE_WIDTH  = 1'b0;
  localparam logic       REG_IMAGE_HEIGHT = 1'b1;
  localparam logic       MODE_LOAD        = 1'b0;
  localparam logic       MODE_PROJECT     = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [CLIP_W-1:0] clip_t;

  typedef struct packed {
    logic [DIV_W-1:0]  rem_x;
    logic [DIV_W-1:0]  rem_y;
    logic [QB-1:0]     q_x;
    logic [QB-1:0]     q_y;
    logic              ovf_x;
    logic              ovf_y;
    logic              neg_x;
    logic              neg_y;
    logic              zero;
    logic [CLIP_W-1:0] den;
  } div_t;

  // Floor-shifted product, sign-extended to the clip width.
  function automatic clip_t scale(input prod_t p);
    logic signed [PROD_W-FRAC_BITS-1:0] s;
    s = p[PROD_W-1:FRAC_BITS];
    return CLIP_W'(s);
  endfunction

  function automatic logic [CLIP_W-1:0] mag(input clip_t v);
    return v[CLIP_W-1] ? CLIP_W'(-v) : CLIP_W'(v);
  endfunction

  // One restoring divide step: {quotient bit, new remainder}.
  function automatic logic [DIV_W:0] div_bit(input logic [DIV_W-1:0] rem,
                                              input logic [DIV_W-1:0] sh);
    if (rem >= sh) return {1'b1, rem - sh};
    return {1'b0, rem};
  endfunction

  function automatic logic [PIX_W-1:0] sat16(input logic signed [T_W-1:0] t);
    if (t > T_W'(32767)) return PIX_W'(16'sh7fff);
    if (t < -T_W'(32768)) return PIX_W'(16'sh8000);
    return t[PIX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/perspective_point_projector_core.sv =====
// Perspective point projector top level: matrix store, clip transform, divide, viewport map.
// Depends on ppp_pkg.
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | mode, entry_index, entry_value, point_x/y/z
// out     | output    | out_valid / out_ready| pixel_x, pixel_y, zero_depth
// cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// One word per cycle while in_ready is high; a point passes 24 register stages on its way
// to the output: input, product, sum, magnitude, scale multiply,
// 18 divide stages, map.
// The restoring divider resolves one quotient bit per stage after its first stage.
// Reset clears the matrix to zero, the sizes to 640 x 480 and all valid bits.
// The whole pipe holds when out_valid is high and out_ready low; in_ready follows.
module perspective_point_projector_core
  import ppp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      mode,
  input  logic [3:0]                entry_index,
  input  logic signed [COORD_W-1:0] entry_value,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [PIX_W-1:0]   pixel_x,
  output logic signed [PIX_W-1:0]   pixel_y,
  output logic                      zero_depth,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  logic                      adv;
  logic [CFG_W-1:0]          image_width;
  logic [CFG_W-1:0]          image_height;
  logic signed [COORD_W-1:0] matrix [16];

  logic                      s0_valid;
  logic signed [COORD_W-1:0] s0_p [3];
  logic                      s1_valid;
  prod_t                     s1_prod [3][3];
  logic signed [COORD_W-1:0] s1_off [3];
  logic                      s2_valid;
  clip_t                     s2_xc, s2_yc, s2_wc;
  logic                      s3_valid;
  logic [CLIP_W-1:0]         s3_ax, s3_ay, s3_ad;
  logic                      s3_neg_x, s3_neg_y, s3_zero;
  logic                      s4_valid;
  logic [NUM_W-1:0]          s4_nx, s4_ny;
  logic [CLIP_W-1:0]         s4_ad;
  logic                      s4_neg_x, s4_neg_y, s4_zero;

  logic [QB:0]               d_valid;
  div_t                      d_st [QB+1];
  div_t                      d_next [QB+1];

  logic [HALF_W-1:0]         w2, h2;
  logic [CFG_W-1:0]          base_y;
  logic signed [T_W-1:0]     t_x, t_y;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign w2       = image_width[CFG_W-1:1];
  assign h2       = image_height[CFG_W-1:1];
  assign base_y   = image_height - CFG_W'(h2);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_IMAGE_WIDTH) image_width <= cfg_data;
      else image_height <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) matrix[i] <= '0;
    end else if (in_valid && adv && mode == MODE_LOAD) begin
      matrix[entry_index] <= entry_value;
    end
  end

  // Front stages: capture, products, row sums, magnitudes, scale by half size.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid && mode == MODE_PROJECT;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_p[0] <= point_x;
      s0_p[1] <= point_y;
      s0_p[2] <= point_z;
      for (int r = 0; r < 3; r++) begin
        // rows 0, 1 and 3 of the matrix; depth row dropped
        for (int c = 0; c < 3; c++) begin
          s1_prod[r][c] <= matrix[(r == 2 ? 12 : r * 4) + c] * s0_p[c];
        end
        s1_off[r] <= matrix[(r == 2 ? 12 : r * 4) + 3];
      end
      s2_xc <= scale(s1_prod[0][0]) + scale(s1_prod[0][1]) + scale(s1_prod[0][2])
               + CLIP_W'(s1_off[0]);
      s2_yc <= scale(s1_prod[1][0]) + scale(s1_prod[1][1]) + scale(s1_prod[1][2])
               + CLIP_W'(s1_off[1]);
      s2_wc <= scale(s1_prod[2][0]) + scale(s1_prod[2][1]) + scale(s1_prod[2][2])
               + CLIP_W'(s1_off[2]);
      s3_ax    <= mag(s2_xc);
      s3_ay    <= mag(s2_yc);
      s3_ad    <= mag(s2_wc);
      s3_neg_x <= s2_xc[CLIP_W-1] != s2_wc[CLIP_W-1];
      s3_neg_y <= s2_yc[CLIP_W-1] == s2_wc[CLIP_W-1];
      s3_zero  <= s2_wc == '0;
      s4_nx    <= NUM_W'(w2) * NUM_W'(s3_ax);
      s4_ny    <= NUM_W'(h2) * NUM_W'(s3_ay);
      s4_ad    <= s3_ad;
      s4_neg_x <= s3_neg_x;
      s4_neg_y <= s3_neg_y;
      s4_zero  <= s3_zero;
    end
  end

  // Divider: stage 0 flags quotients too wide for the QB-bit quotient field,
  // each later stage resolves one quotient bit, most significant first.
  always_ff @(posedge clk) begin
    if (rst) d_valid <= '0;
    else if (adv) d_valid <= {d_valid[QB-1:0], s4_valid};
  end

  always_comb begin
    d_next[0].rem_x = DIV_W'(s4_nx);
    d_next[0].rem_y = DIV_W'(s4_ny);
    d_next[0].q_x   = '0;
    d_next[0].q_y   = '0;
    d_next[0].ovf_x = DIV_W'(s4_nx) >= (DIV_W'(s4_ad) << QB);
    d_next[0].ovf_y = DIV_W'(s4_ny) >= (DIV_W'(s4_ad) << QB);
    d_next[0].neg_x = s4_neg_x;
    d_next[0].neg_y = s4_neg_y;
    d_next[0].zero  = s4_zero;
    d_next[0].den   = s4_ad;
    for (int j = 1; j <= QB; j++) begin
      logic [DIV_W-1:0] sh;
      logic [DIV_W:0]   rx, ry;
      sh = DIV_W'(d_st[j-1].den) << (QB - j);
      rx = div_bit(d_st[j-1].rem_x, sh);
      ry = div_bit(d_st[j-1].rem_y, sh);
      d_next[j]           = d_st[j-1];
      d_next[j].rem_x     = rx[DIV_W-1:0];
      d_next[j].rem_y     = ry[DIV_W-1:0];
      d_next[j].q_x[QB-j] = rx[DIV_W];
      d_next[j].q_y[QB-j] = ry[DIV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j <= QB; j++) d_st[j] <= d_next[j];
    end
  end

  // Viewport map: x adds to half width, y subtracts from the flipped base.
  always_comb begin
    if (d_st[QB].neg_x) t_x = T_W'(w2) - T_W'(d_st[QB].q_x);
    else t_x = T_W'(w2) + T_W'(d_st[QB].q_x);
    if (d_st[QB].neg_x && d_st[QB].rem_x != '0 && t_x > 0) t_x = t_x - T_W'(1);
    if (d_st[QB].neg_y) t_y = T_W'(base_y) - T_W'(d_st[QB].q_y);
    else t_y = T_W'(base_y) + T_W'(d_st[QB].q_y);
    if (d_st[QB].neg_y && d_st[QB].rem_y != '0 && t_y > 0) t_y = t_y - T_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= d_valid[QB];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_depth <= d_st[QB].zero;
      if (d_st[QB].zero) begin
        pixel_x <= '0;
        pixel_y <= '0;
      end else begin
        if (d_st[QB].ovf_x) pixel_x <= d_st[QB].neg_x ? 16'sh8000 : 16'sh7fff;
        else pixel_x <= sat16(t_x);
        if (d_st[QB].ovf_y) pixel_y <= d_st[QB].neg_y ? 16'sh8000 : 16'sh7fff;
        else pixel_y <= sat16(t_y);
      end
    end
  end

endmodule
